// File: rtl/utf8d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types and constants for the UTF-8 byte stream decoder: field widths,
// result status codes, register indexes and lead byte masks.
// ----------------------------------------------------------------------------
package utf8d_pkg;

    // field widths
    localparam int BYTE_W   = 8;
    localparam int CP_W     = 21;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 3;
    localparam int LEFT_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_CHAR     = 2'd0,
        ST_UNKNOWN  = 2'd1,
        ST_TOO_LONG = 2'd2
    } t_status;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX_SEQ_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SUPPRESS    = 2'd1;

    // register reset values
    localparam logic [LEN_W-1:0] MAX_SEQ_LEN_RST = 3'd4;
    localparam logic             SUPPRESS_RST    = 1'b0;

    // sequence lengths
    localparam logic [LEN_W-1:0] LEN_2 = 3'd2;
    localparam logic [LEN_W-1:0] LEN_3 = 3'd3;
    localparam logic [LEN_W-1:0] LEN_4 = 3'd4;

    // lead byte ranges
    localparam logic [BYTE_W-1:0] LEAD2_LO = 8'hC2;
    localparam logic [BYTE_W-1:0] LEAD2_HI = 8'hDF;
    localparam logic [BYTE_W-1:0] LEAD3_LO = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD3_HI = 8'hEF;
    localparam logic [BYTE_W-1:0] LEAD4_LO = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD4_HI = 8'hF7;

    // payload masks for lead bytes
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'h1F;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'h0F;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'h07;

endpackage

// File: rtl/utf8_byte_stream_decoder.sv
`timescale 1ns / 1ps
// path: a byte is captured in the input register, decoded combinationally and its
//   result is loaded into the result register
// throughput: one byte per cycle, limited only by the output stall
// reset: synchronous, active low; clears the pipeline valids and the sequence
//   state, max_sequence_length returns to 4 and suppress_errors to 0
// ----------------------------------------------------------------------------
// utf8_byte_stream_decoder
// Decodes a stream of UTF-8 bytes into code points. Input register, one
// stage of decode logic with the sequence state, then a result register.
// ----------------------------------------------------------------------------
module utf8_byte_stream_decoder
    import utf8d_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // byte input channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [BYTE_W-1:0]     i_byte_in,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [CP_W-1:0]       o_code_point,
    output logic [STATUS_W-1:0]   o_status,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // configuration registers
    logic [LEN_W-1:0] r_max_len;
    logic             r_suppress;

    // input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;

    // sequence state
    logic              r_in_seq;
    logic [LEFT_W-1:0] r_bytes_left;
    logic [CP_W-1:0]   r_accum;
    logic              n_in_seq;
    logic [LEFT_W-1:0] n_bytes_left;
    logic [CP_W-1:0]   n_accum;

    // result register
    logic            r_out_valid;
    logic [CP_W-1:0] r_out_cp;
    t_status         r_out_status;

    // decode outputs
    logic            dec_emit;
    logic [CP_W-1:0] dec_cp;
    t_status         dec_status;
    logic [LEN_W-1:0]  lead_len;
    logic [BYTE_W-1:0] lead_bits;
    logic              lead_ok;
    logic [LEFT_W-1:0] left_dec;

    // handshake control
    logic out_load;
    logic step_fire;

    assign out_load   = !r_out_valid || !i_out_stall;
    assign step_fire  = r_in_valid && out_load;
    assign o_in_stall = r_in_valid && !out_load;
    assign o_cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len  <= MAX_SEQ_LEN_RST;
            r_suppress <= SUPPRESS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_IDX_MAX_SEQ_LEN) begin
                r_max_len <= i_cfg_data;
            end else if (i_cfg_index == CFG_IDX_SUPPRESS) begin
                r_suppress <= i_cfg_data[0];
            end
        end
    end

    // input register: takes a beat whenever it is empty or moving on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_byte <= i_byte_in;
        end
    end

    // lead byte classification
    always_comb begin
        lead_ok   = 1'b1;
        lead_len  = LEN_2;
        lead_bits = '0;
        priority if (r_in_byte >= LEAD2_LO && r_in_byte <= LEAD2_HI) begin
            lead_len  = LEN_2;
            lead_bits = r_in_byte & LEAD2_MASK;
        end else if (r_in_byte >= LEAD3_LO && r_in_byte <= LEAD3_HI) begin
            lead_len  = LEN_3;
            lead_bits = r_in_byte & LEAD3_MASK;
        end else if (r_in_byte >= LEAD4_LO && r_in_byte <= LEAD4_HI) begin
            lead_len  = LEN_4;
            lead_bits = r_in_byte & LEAD4_MASK;
        end else begin
            lead_ok = 1'b0;
        end
    end

    assign left_dec = r_bytes_left - LEFT_W'(1);

    // decode step and next sequence state
    always_comb begin
        n_in_seq     = r_in_seq;
        n_bytes_left = r_bytes_left;
        n_accum      = r_accum;
        dec_emit     = 1'b0;
        dec_cp       = '0;
        dec_status   = ST_CHAR;
        if (r_in_seq) begin
            // continuation beat, taken without any check
            n_accum      = {r_accum[CP_W-7:0], r_in_byte[5:0]};
            n_bytes_left = left_dec;
            if (left_dec == '0) begin
                n_in_seq = 1'b0;
                dec_emit = 1'b1;
                dec_cp   = {r_accum[CP_W-7:0], r_in_byte[5:0]};
            end
        end else if (!r_in_byte[7] && r_in_byte != '0) begin
            // plain ascii, apart from the zero byte
            dec_emit = 1'b1;
            dec_cp   = CP_W'(r_in_byte);
        end else if (!lead_ok) begin
            dec_emit   = !r_suppress;
            dec_status = ST_UNKNOWN;
        end else if (lead_len > r_max_len) begin
            dec_emit   = !r_suppress;
            dec_status = ST_TOO_LONG;
        end else begin
            // open a sequence
            n_in_seq     = 1'b1;
            n_bytes_left = LEFT_W'(lead_len - LEN_W'(1));
            n_accum      = CP_W'(lead_bits);
        end
    end

    // sequence state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_seq     <= 1'b0;
            r_bytes_left <= '0;
            r_accum      <= '0;
        end else if (step_fire) begin
            r_in_seq     <= n_in_seq;
            r_bytes_left <= n_bytes_left;
            r_accum      <= n_accum;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= step_fire && dec_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_fire && dec_emit) begin
            r_out_cp     <= dec_cp;
            r_out_status <= dec_status;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_code_point = r_out_cp;
    assign o_status     = r_out_status;

endmodule

// File: rtl/utf8d_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_port_checks
// Port level checks for the UTF-8 byte stream decoder, bound to the top level.
// ----------------------------------------------------------------------------
module utf8d_port_checks
    import utf8d_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input logic [CP_W-1:0]       o_code_point,
    input logic [STATUS_W-1:0]   o_status
);

    // a result beat held back stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result beat dropped while stalled");

    // a held back result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_code_point) && $stable(o_status))
        else $error("result payload changed while stalled");

    // the input side only stalls behind a stalled full result register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output back pressure");

    // error results carry a zero code point and only defined statuses appear
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_CHAR) ||
                        ((o_status == ST_UNKNOWN || o_status == ST_TOO_LONG) &&
                         o_code_point == '0))
        else $error("bad status or non-zero code point on error result");

endmodule

bind utf8_byte_stream_decoder utf8d_port_checks u_utf8d_port_checks (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_code_point (o_code_point),
    .o_status     (o_status)
);
